FILE: hw/rtl/vapc_pkg.sv
`default_nettype none
package vapc_pkg;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned IDX_W = 6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_PT,
    OP_CAP_I,
    OP_BL_MUL,
    OP_SCAN_INIT,
    OP_CAP_K,
    OP_K_MUL,
    OP_K_UPD,
    OP_G_SET,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_P_WR,
    OP_RD_OUT
  } dp_op_e;

  // dir: 0 = forward p1 sweep, 1 = backward p0 sweep
  typedef struct packed {
    dp_op_e op;
    logic   dir;
    logic   first;
    logic   zero;
  } dp_cmd_t;

  typedef struct packed {
    logic cand_ok;
    logic less;
    logic below;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/venn_abers_p0_p1_calibration.sv
// Channel  | Signals                                         | Transfer
// ---------+-------------------------------------------------+------------------------
// in       | weight_cumsum_i, label_cumsum_i, last_entry_i   | start && !busy
// result   | point_index_o, p0_*/p1_*, overflowed_o, last_*  | result_valid_o, 1 cycle
//
// A non-last entry is taken while idle. The last one starts the run: for each of
// the n+1 points, each sweep either keeps the gradient or rescans the candidates,
// skipping unusable ones (one multiplier pair, one memory read port), then a
// bit-serial divide quantizes the gradient; after both sweeps each point is emitted.
// busy stays high for the whole run. Reset clears entry count and overflow;
// stores are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module venn_abers_p0_p1_calibration #(
  parameter int unsigned MAX_ENTRIES = 63,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [vapc_pkg::IN_W-1:0] weight_cumsum_i,
  input  wire logic [vapc_pkg::IN_W-1:0] label_cumsum_i,
  input  wire logic                      last_entry_i,
  output logic                           result_valid_o,
  output logic [vapc_pkg::IDX_W-1:0]     point_index_o,
  output logic [FRAC_BITS:0]             p0_value_o,
  output logic                           p0_unbounded_o,
  output logic [FRAC_BITS:0]             p1_value_o,
  output logic                           p1_unbounded_o,
  output logic                           overflowed_o,
  output logic                           last_result_o
);
  import vapc_pkg::*;

  localparam int unsigned EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned PAW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 2);

  dp_cmd_t        cmd;
  dp_sts_t        sts;
  logic [EAW-1:0] ent_addr;
  logic [PAW-1:0] p_addr;

  vapc_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .EAW(EAW),
    .PAW(PAW),
    .CW(CW)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .last_entry_i(last_entry_i),
    .sts_i(sts),
    .cmd_o(cmd),
    .ent_addr_o(ent_addr),
    .p_addr_o(p_addr),
    .busy_o(busy),
    .out_valid_o(result_valid_o),
    .out_index_o(point_index_o),
    .out_last_o(last_result_o),
    .out_ovf_o(overflowed_o)
  );

  vapc_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS(FRAC_BITS),
    .EAW(EAW),
    .PAW(PAW)
  ) u_dp (
    .clk_i(clk_i),
    .cmd_i(cmd),
    .ent_addr_i(ent_addr),
    .p_addr_i(p_addr),
    .weight_i(weight_cumsum_i),
    .label_i(label_cumsum_i),
    .sts_o(sts),
    .p0_value_o(p0_value_o),
    .p0_flag_o(p0_unbounded_o),
    .p1_value_o(p1_value_o),
    .p1_flag_o(p1_unbounded_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/vapc_datapath.sv
`default_nettype none
module vapc_datapath #(
  parameter int unsigned MAX_ENTRIES = 63,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned EAW         = 6,
  parameter int unsigned PAW         = 6
) (
  input  wire logic                        clk_i,
  input  wire vapc_pkg::dp_cmd_t           cmd_i,
  input  wire logic [EAW-1:0]              ent_addr_i,
  input  wire logic [PAW-1:0]              p_addr_i,
  input  wire logic [vapc_pkg::IN_W-1:0]   weight_i,
  input  wire logic [vapc_pkg::IN_W-1:0]   label_i,
  output vapc_pkg::dp_sts_t                sts_o,
  output logic [FRAC_BITS:0]               p0_value_o,
  output logic                             p0_flag_o,
  output logic [FRAC_BITS:0]               p1_value_o,
  output logic                             p1_flag_o
);
  import vapc_pkg::*;

  localparam int unsigned CB  = COUNT_BITS;
  localparam int unsigned VW  = COUNT_BITS + 2;
  localparam int unsigned WW  = FRAC_BITS + 2;
  localparam int unsigned DCW = $clog2(FRAC_BITS);

  logic [CB-1:0] w_mem [MAX_ENTRIES];
  logic [CB-1:0] l_mem [MAX_ENTRIES];
  logic [WW-1:0] p0_mem [MAX_ENTRIES+1];
  logic [WW-1:0] p1_mem [MAX_ENTRIES+1];

  logic [CB-1:0] rx_q, ry_q;
  logic          rz_q;
  logic signed [VW-1:0] xi_q, yi_q, xc_q, yc_q;
  logic signed [VW-1:0] sn_q, sd_q;
  logic                 s_ok_q;
  logic signed [VW-1:0] gn_q, gd_q, bn_q, bd_q;
  logic                 gpos_q, gneg_q, bpos_q, bneg_q, found_q;
  logic signed [2*VW-1:0] prod1_q, prod2_q;
  logic [VW-1:0]        rem_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [DCW-1:0]       dcnt_q;
  logic [WW-1:0]        o0_q, o1_q;

  logic signed [VW-1:0] px, py, dxk, dyk, dxl;
  logic [VW:0]          dtrial;
  logic [FRAC_BITS:0]   wval;
  logic [WW-1:0]        word;

  always_comb begin
    px  = rz_q ? '0 : $signed({2'b00, rx_q});
    py  = rz_q ? '0 : $signed({2'b00, ry_q});
    dxl = xi_q - xc_q;
    if (cmd_i.dir) begin
      dxk = px - xi_q - VW'(1);
      dyk = py - yi_q;
    end else begin
      dxk = px + VW'(1) - xi_q;
      dyk = py + VW'(1) - yi_q;
    end
    dtrial = {rem_q, 1'b0};

    if (gpos_q || gneg_q) begin
      if (dxl == '0) sts_o.below = yi_q < yc_q;
      else sts_o.below = (dxl > 0) == gpos_q;
    end else begin
      sts_o.below = prod1_q < prod2_q;
    end
    if (cmd_i.dir) sts_o.less = (bpos_q || bneg_q) ? bneg_q : (prod1_q < prod2_q);
    else sts_o.less = (bpos_q || bneg_q) ? bpos_q : (prod1_q < prod2_q);
    sts_o.cand_ok  = s_ok_q;
    sts_o.div_done = dcnt_q == DCW'(FRAC_BITS - 1);

    if (gpos_q) wval = {1'b1, {FRAC_BITS{1'b0}}};
    else if (gneg_q) wval = '0;
    else if (gn_q <= 0) wval = '0;
    else if (gn_q >= gd_q) wval = {1'b1, {FRAC_BITS{1'b0}}};
    else wval = {1'b0, quo_q};
    word = {gpos_q | gneg_q, wval};
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        w_mem[ent_addr_i] <= CB'(weight_i);
        l_mem[ent_addr_i] <= CB'(label_i);
      end
      OP_RD_PT: begin
        rx_q <= w_mem[ent_addr_i];
        ry_q <= l_mem[ent_addr_i];
        rz_q <= cmd_i.zero;
      end
      OP_CAP_I: begin
        xi_q <= px;
        yi_q <= py;
      end
      OP_BL_MUL: begin
        prod1_q <= (yi_q - yc_q) * gd_q;
        prod2_q <= dxl * gn_q;
      end
      OP_SCAN_INIT: begin
        xc_q    <= xi_q;
        yc_q    <= yi_q;
        bpos_q  <= !cmd_i.dir;
        bneg_q  <= cmd_i.dir;
        bn_q    <= '0;
        bd_q    <= VW'(1);
        found_q <= 1'b0;
      end
      OP_CAP_K: begin
        s_ok_q <= cmd_i.dir ? (dxk != '0) : (dxk > 0);
        if (dxk < 0) begin
          sn_q <= -dyk;
          sd_q <= -dxk;
        end else begin
          sn_q <= dyk;
          sd_q <= dxk;
        end
      end
      OP_K_MUL: begin
        if (cmd_i.dir) begin
          prod1_q <= bn_q * sd_q;
          prod2_q <= sn_q * bd_q;
        end else begin
          prod1_q <= sn_q * bd_q;
          prod2_q <= bn_q * sd_q;
        end
      end
      OP_K_UPD: begin
        if (sts_o.less) begin
          bn_q    <= sn_q;
          bd_q    <= sd_q;
          bpos_q  <= 1'b0;
          bneg_q  <= 1'b0;
          found_q <= 1'b1;
        end
      end
      OP_G_SET: begin
        if (cmd_i.dir || cmd_i.first || found_q) begin
          gn_q   <= bn_q;
          gd_q   <= bd_q;
          gpos_q <= bpos_q;
          gneg_q <= bneg_q;
        end
      end
      OP_DIV_INIT: begin
        rem_q  <= gn_q;
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      OP_DIV_STEP: begin
        if (dtrial >= {1'b0, gd_q}) begin
          rem_q <= VW'(dtrial - {1'b0, gd_q});
          quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_q <= VW'(dtrial);
          quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + DCW'(1);
      end
      OP_P_WR: begin
        if (cmd_i.dir) p0_mem[p_addr_i] <= word;
        else p1_mem[p_addr_i] <= word;
      end
      OP_RD_OUT: begin
        o0_q <= p0_mem[p_addr_i];
        o1_q <= p1_mem[p_addr_i];
      end
      default: ;
    endcase
  end

  assign p0_value_o = o0_q[FRAC_BITS:0];
  assign p0_flag_o  = o0_q[FRAC_BITS+1];
  assign p1_value_o = o1_q[FRAC_BITS:0];
  assign p1_flag_o  = o1_q[FRAC_BITS+1];

endmodule
`default_nettype wire

FILE: hw/rtl/vapc_ctrl.sv
`default_nettype none
module vapc_ctrl #(
  parameter int unsigned MAX_ENTRIES = 63,
  parameter int unsigned EAW         = 6,
  parameter int unsigned PAW         = 6,
  parameter int unsigned CW          = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       last_entry_i,
  input  wire vapc_pkg::dp_sts_t          sts_i,
  output vapc_pkg::dp_cmd_t               cmd_o,
  output logic [EAW-1:0]                  ent_addr_o,
  output logic [PAW-1:0]                  p_addr_o,
  output logic                            busy_o,
  output logic                            out_valid_o,
  output logic [vapc_pkg::IDX_W-1:0]      out_index_o,
  output logic                            out_last_o,
  output logic                            out_ovf_o
);
  import vapc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PT_RD, S_PT_CAP, S_BL_MUL, S_BL_CHK, S_SCAN_INIT, S_K_CHK,
    S_K_RD, S_K_CAP, S_K_MUL, S_K_UPD, S_G_SET, S_DIV_INIT, S_DIV, S_P_WR,
    S_E_RD, S_E_OUT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] n_q, i_q, k_q;
  logic          ovf_q, dir_q;
  logic          first;
  logic [CW-1:0] pt;

  assign first = dir_q ? (i_q == n_q) : (i_q == '0);
  assign pt    = (state_q == S_K_RD) ? k_q : i_q;

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.dir   = dir_q;
    cmd_o.first = first;
    cmd_o.zero  = pt == '0;
    ent_addr_o  = (pt == '0) ? '0 : EAW'(pt - CW'(1));
    p_addr_o    = PAW'(i_q);
    unique case (state_q)
      S_IDLE: begin
        ent_addr_o = EAW'(n_q);
        if (start_i && n_q < CW'(MAX_ENTRIES)) cmd_o.op = OP_LOAD;
      end
      S_PT_RD, S_K_RD: cmd_o.op = OP_RD_PT;
      S_PT_CAP:    cmd_o.op = OP_CAP_I;
      S_BL_MUL:    cmd_o.op = OP_BL_MUL;
      S_SCAN_INIT: cmd_o.op = OP_SCAN_INIT;
      S_K_CAP:     cmd_o.op = OP_CAP_K;
      S_K_MUL:     cmd_o.op = sts_i.cand_ok ? OP_K_MUL : OP_NONE;
      S_K_UPD:     cmd_o.op = OP_K_UPD;
      S_G_SET:     cmd_o.op = OP_G_SET;
      S_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      S_DIV:       cmd_o.op = OP_DIV_STEP;
      S_P_WR:      cmd_o.op = OP_P_WR;
      S_E_RD:      cmd_o.op = OP_RD_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o      = state_q != S_IDLE;
  assign out_valid_o = state_q == S_E_OUT;
  assign out_index_o = IDX_W'(i_q);
  assign out_last_o  = i_q == n_q;
  assign out_ovf_o   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      k_q     <= '0;
      ovf_q   <= 1'b0;
      dir_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (n_q < CW'(MAX_ENTRIES)) n_q <= n_q + CW'(1);
            else ovf_q <= 1'b1;
            if (last_entry_i) begin
              dir_q   <= 1'b0;
              i_q     <= '0;
              state_q <= S_PT_RD;
            end
          end
        end
        S_PT_RD:  state_q <= S_PT_CAP;
        S_PT_CAP: state_q <= first ? S_SCAN_INIT : S_BL_MUL;
        S_BL_MUL: state_q <= S_BL_CHK;
        S_BL_CHK: state_q <= sts_i.below ? S_SCAN_INIT : S_DIV_INIT;
        S_SCAN_INIT: begin
          k_q     <= dir_q ? '0 : i_q + CW'(1);
          state_q <= S_K_CHK;
        end
        S_K_CHK: begin
          if (dir_q ? (k_q < i_q) : (k_q <= n_q)) state_q <= S_K_RD;
          else state_q <= S_G_SET;
        end
        S_K_RD:  state_q <= S_K_CAP;
        S_K_CAP: state_q <= S_K_MUL;
        S_K_MUL: begin
          if (sts_i.cand_ok) begin
            state_q <= S_K_UPD;
          end else begin
            k_q     <= k_q + CW'(1);
            state_q <= S_K_CHK;
          end
        end
        S_K_UPD: begin
          k_q     <= k_q + CW'(1);
          state_q <= S_K_CHK;
        end
        S_G_SET:    state_q <= S_DIV_INIT;
        S_DIV_INIT: state_q <= S_DIV;
        S_DIV:      if (sts_i.div_done) state_q <= S_P_WR;
        S_P_WR: begin
          if (!dir_q) begin
            if (i_q == n_q) dir_q <= 1'b1;
            else i_q <= i_q + CW'(1);
            state_q <= S_PT_RD;
          end else if (i_q == '0) begin
            state_q <= S_E_RD;
          end else begin
            i_q     <= i_q - CW'(1);
            state_q <= S_PT_RD;
          end
        end
        S_E_RD: state_q <= S_E_OUT;
        S_E_OUT: begin
          if (i_q == n_q) begin
            n_q     <= '0;
            ovf_q   <= 1'b0;
            i_q     <= '0;
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_E_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vapc_pkg::*;

  localparam int MAX_N = 63;
  localparam int FB = 16;
  localparam longint Q_ONE = 64'd1 << FB;

  typedef struct {
    longint num;
    longint den;
    int     inf;
  } slope_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [FB:0]      p0v;
    logic             p0u;
    logic [FB:0]      p1v;
    logic             p1u;
    logic             ovf;
    logic             last;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IN_W-1:0] weight_cumsum_i = '0;
  logic [IN_W-1:0] label_cumsum_i = '0;
  logic last_entry_i = 1'b0;
  logic result_valid_o;
  logic [IDX_W-1:0] point_index_o;
  logic [FB:0] p0_value_o, p1_value_o;
  logic p0_unbounded_o, p1_unbounded_o, overflowed_o, last_result_o;

  venn_abers_p0_p1_calibration u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  logic [15:0] weight_mem[MAX_N];
  logic [15:0] label_mem[MAX_N];
  int          loaded;
  bit          dropped;
  point_t      pending_points[$];
  int          n_errors;
  int          n_points;
  int          n_runs;
  int          n_items;
  int          n_ovf_runs;

  function automatic slope_t mk_slope(longint dy, longint dx);
    slope_t s;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
    end
    s.num = dy;
    s.den = dx;
    s.inf = 0;
    return s;
  endfunction

  function automatic bit slope_lt(slope_t a, slope_t b);
    if (a.inf != b.inf) return a.inf < b.inf;
    if (a.inf != 0) return 1'b0;
    return a.num * b.den < b.num * a.den;
  endfunction

  function automatic bit under_line(longint yi, longint yc, longint dx, slope_t g);
    if (g.inf == 0) return (yi - yc) * g.den < dx * g.num;
    if (dx == 0) return yi < yc;
    return (dx > 0) == (g.inf > 0);
  endfunction

  function automatic logic [FB+1:0] quantize(slope_t g);
    longint q;
    logic   f;
    f = 1'b0;
    if (g.inf > 0) begin
      q = Q_ONE;
      f = 1'b1;
    end else if (g.inf < 0) begin
      q = 0;
      f = 1'b1;
    end else if (g.num <= 0) begin
      q = 0;
    end else if (g.num >= g.den) begin
      q = Q_ONE;
    end else begin
      q = (g.num << FB) / g.den;
    end
    return {f, q[FB:0]};
  endfunction

  // both gradient sweeps over the loaded points, then queue one point per index
  task automatic calibrate_run();
    longint xs[MAX_N+1], ys[MAX_N+1], dx;
    logic [FB+1:0] p0w[MAX_N+1], p1w[MAX_N+1];
    slope_t g, best, s;
    bit found;
    int n, c;
    point_t pt;
    n = loaded;
    xs[0] = 0;
    ys[0] = 0;
    for (int k = 1; k <= n; k++) begin
      xs[k] = weight_mem[k-1];
      ys[k] = label_mem[k-1];
    end
    g = '{0, 1, 1};
    c = 0;
    for (int i = 0; i <= n; i++) begin
      if (i == 0 || under_line(ys[i], ys[c], xs[i] - xs[c], g)) begin
        best = '{0, 1, 1};
        found = 1'b0;
        for (int k = i + 1; k <= n; k++) begin
          dx = xs[k] + 1 - xs[i];
          if (dx > 0) begin
            s = mk_slope(ys[k] + 1 - ys[i], dx);
            if (slope_lt(s, best)) begin
              best = s;
              found = 1'b1;
            end
          end
        end
        if (i == 0 || found) g = best;
        c = i;
      end
      p1w[i] = quantize(g);
    end
    g = '{0, 1, -1};
    c = n;
    for (int i = n; i >= 0; i--) begin
      if (i == n || under_line(ys[i], ys[c], xs[i] - xs[c], g)) begin
        best = '{0, 1, -1};
        for (int k = 0; k < i; k++) begin
          dx = xs[k] - (xs[i] + 1);
          if (dx != 0) begin
            s = mk_slope(ys[k] - ys[i], dx);
            if (slope_lt(best, s)) best = s;
          end
        end
        g = best;
        c = i;
      end
      p0w[i] = quantize(g);
    end
    for (int i = 0; i <= n; i++) begin
      pt.idx = i[IDX_W-1:0];
      pt.p0v = p0w[i][FB:0];
      pt.p0u = p0w[i][FB+1];
      pt.p1v = p1w[i][FB:0];
      pt.p1u = p1w[i][FB+1];
      pt.ovf = dropped;
      pt.last = (i == n);
      pending_points.push_back(pt);
    end
    if (dropped) n_ovf_runs++;
    n_runs++;
    loaded = 0;
    dropped = 1'b0;
  endtask

  task automatic send_entry(logic [15:0] w, logic [15:0] l, logic lst, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    weight_cumsum_i = w;
    label_cumsum_i = l;
    last_entry_i = lst;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    n_items++;
    if (loaded < MAX_N) begin
      weight_mem[loaded] = w;
      label_mem[loaded] = l;
      loaded++;
    end else begin
      dropped = 1'b1;
    end
    if (lst) calibrate_run();
  endtask

  // ordered: monotone cumulative counts with random increments, labels never above weights; else random values
  task automatic send_run(int n, bit busy_gaps, bit ordered);
    int w, l, dw, dl, gap;
    w = 0;
    l = 0;
    for (int k = 0; k < n; k++) begin
      if (ordered) begin
        dw = $urandom_range(($urandom_range(0, 3) == 0) ? 2000 : 6, 1);
        dl = $urandom_range(dw, 0);
        w = (w + dw > 65535) ? 65535 : w + dw;
        l = (l + dl > w) ? w : l + dl;
      end else begin
        w = $urandom_range(65535, 0);
        l = $urandom_range(65535, 0);
      end
      gap = busy_gaps ? $urandom_range(16, 0) : 0;
      send_entry(w[15:0], l[15:0], k == n - 1, gap);
    end
  endtask

  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && result_valid_o) begin
      n_points++;
      if (pending_points.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result, index %0d", point_index_o);
      end else begin
        e = pending_points.pop_front();
        if (point_index_o !== e.idx || p0_value_o !== e.p0v || p0_unbounded_o !== e.p0u ||
            p1_value_o !== e.p1v || p1_unbounded_o !== e.p1u ||
            overflowed_o !== e.ovf || last_result_o !== e.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp idx %0d p0 %0d/%0b p1 %0d/%0b ovf %0b last %0b",
                     e.idx, e.p0v, e.p0u, e.p1v, e.p1u, e.ovf, e.last,
                     " | got idx %0d p0 %0d/%0b p1 %0d/%0b ovf %0b last %0b",
                     point_index_o, p0_value_o, p0_unbounded_o, p1_value_o,
                     p1_unbounded_o, overflowed_o, last_result_o);
        end
      end
    end
  end

  task automatic test_single_entries();
    send_entry(16'd0, 16'd0, 1'b1, 0);
    send_entry(16'hFFFF, 16'hFFFF, 1'b1, 3);
    send_entry(16'd10, 16'd0, 1'b1, 0);
    send_entry(16'd0, 16'hFFFF, 1'b1, 1);
  endtask

  task automatic test_extremes();
    send_entry(16'd0, 16'd0, 1'b0, 0);
    send_entry(16'd0, 16'd0, 1'b0, 0);
    send_entry(16'hFFFF, 16'd0, 1'b0, 2);
    send_entry(16'hFFFF, 16'hFFFF, 1'b0, 0);
    send_entry(16'd1, 16'hFFFF, 1'b0, 0);
    send_entry(16'h8000, 16'h7FFF, 1'b1, 5);
    send_entry(16'd1, 16'd1, 1'b0, 0);
    send_entry(16'd2, 16'd1, 1'b0, 0);
    send_entry(16'd3, 16'd3, 1'b1, 0);
  endtask

  task automatic test_capacity();
    send_run(MAX_N, 1'b0, 1'b1);
    send_run(MAX_N + 3, 1'b1, 1'b1);
  endtask

  task automatic test_random_runs();
    int n;
    while (n_items < 360) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_N, 20) : $urandom_range(10, 1);
      send_run(n, $urandom_range(0, 2) != 0, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    loaded = 0;
    dropped = 1'b0;
    n_errors = 0;
    n_points = 0;
    n_runs = 0;
    n_items = 0;
    n_ovf_runs = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_single_entries();
    test_extremes();
    test_capacity();
    test_random_runs();
    @(negedge clk_i);
    start = 1'b0;
    wait (pending_points.size() == 0);
    repeat (200) @(posedge clk_i);
    n_errors += pending_points.size();
    $display("%0d entries in %0d runs (%0d with dropped entries), %0d points checked",
             n_items, n_runs, n_ovf_runs, n_points);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors", n_errors);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vapc_pkg.sv
hw/rtl/vapc_datapath.sv
hw/rtl/vapc_ctrl.sv
hw/rtl/venn_abers_p0_p1_calibration.sv
sim/testbench.sv
